// ===== rtl/core/ctbm_pkg.sv =====
// Shared types, register codes and taper table math for the cosine taper band mask.
// No dependencies; imported by cosine_taper_band_mask_top.
package ctbm_pkg;

	localparam int FFT_LENGTH_DEF       = 1024;
	localparam int TAPER_TABLE_BITS_DEF = 10;

	localparam int BIN_W  = 10;
	localparam int GAIN_W = 16;
	localparam int CFG_W  = 10;

	localparam logic [GAIN_W-1:0] ONE_Q15 = 16'h8000;
	localparam logic [63:0]       PI_Q30  = 64'd3373259426;

	// configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_PASS_MODE    = 3'd0;
	localparam cfg_idx_t CFG_HP_BIN       = 3'd1;
	localparam cfg_idx_t CFG_HP_HALFWIDTH = 3'd2;
	localparam cfg_idx_t CFG_LP_BIN       = 3'd3;
	localparam cfg_idx_t CFG_LP_HALFWIDTH = 3'd4;

	// pass_mode codes; the unused code behaves as band-pass
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_BAND = 2'd0;
	localparam mode_t MODE_LOW  = 2'd1;
	localparam mode_t MODE_HIGH = 2'd2;

	localparam mode_t            RST_PASS_MODE    = MODE_BAND;
	localparam logic [BIN_W-1:0] RST_HP_BIN       = 10'd0;
	localparam logic [BIN_W-1:0] RST_HP_HALFWIDTH = 10'd3;
	localparam logic [BIN_W-1:0] RST_LP_BIN       = 10'd512;
	localparam logic [BIN_W-1:0] RST_LP_HALFWIDTH = 10'd0;

	// a zero high-pass half width acts as this width
	localparam logic [BIN_W-1:0] HP_HALFWIDTH_ZERO_SUB = 10'd3;

	// which part of a factor's response a bin falls in
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_ONE,
		SEL_TAPER
	} sel_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin;
		sel_t             hp_sel;
		sel_t             lp_sel;
		logic             over;   // bin beyond the spectrum half
	} item_t;

	// sin^2(pi/2 * q/2^tb) in Q15, for 0 <= q <= 2^(tb-1); elaboration only
	// Taylor terms of sin are divided by (2n)(2n+1): 6, 20, 42, 72
	function automatic logic [15:0] sin_sq_q15(input logic [63:0] q, input int tb);
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] t;
		logic [63:0] sum;
		logic [63:0] s2;
		y   = (PI_Q30 * q) >> (tb + 1);
		y2  = (y * y) >> 30;
		t   = y;
		sum = y;
		t   = ((t * y2) >> 30) / 64'd6;
		sum = sum - t;
		t   = ((t * y2) >> 30) / 64'd20;
		sum = sum + t;
		t   = ((t * y2) >> 30) / 64'd42;
		sum = sum - t;
		t   = ((t * y2) >> 30) / 64'd72;
		sum = sum + t;
		s2 = (sum * sum) >> 30;
		return 16'((s2 + 64'd16384) >> 15);
	endfunction

endpackage

// ===== rtl/core/cosine_taper_band_mask_top.sv =====
// Cosine taper band mask: per-bin gain from a high-pass and a low-pass raised-cosine edge.
// Depends on ctbm_pkg (types, register codes, taper table function).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   input   | in        | in_valid / in_stall  | bin_index
//   output  | out       | out_valid / out_stall| bin_out, gain
//   config  | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One bin per clock while the output is not stalled; the pipeline depth is set by
// the taper phase quotient, which resolves one bit per pipeline stage.
// Reset clears the stage valid bits and loads the register defaults.
// A stalled output holds; upstream stages keep moving into empty slots, so the
// input stalls only when every stage holds an item and the output is stalled.
module cosine_taper_band_mask_top #(
	parameter int FFT_LENGTH       = ctbm_pkg::FFT_LENGTH_DEF,
	parameter int TAPER_TABLE_BITS = ctbm_pkg::TAPER_TABLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ctbm_pkg::BIN_W-1:0]    bin_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ctbm_pkg::BIN_W-1:0]    bin_out,
	output logic [ctbm_pkg::GAIN_W-1:0]   gain,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  ctbm_pkg::cfg_idx_t            cfg_index,
	input  logic [ctbm_pkg::CFG_W-1:0]    cfg_data
);
	import ctbm_pkg::*;

	localparam int N         = 1 << TAPER_TABLE_BITS;
	localparam int HALF      = N / 2;
	localparam int AW        = TAPER_TABLE_BITS;        // table depth HALF+1
	localparam int QW        = TAPER_TABLE_BITS + 1;    // phase 0..N
	localparam int KW        = 11;                      // taper offset, below 2w
	localparam int NW        = KW + TAPER_TABLE_BITS + 1;
	localparam int DW        = BIN_W + 1;

	localparam int ST_DEC     = 1;
	localparam int ST_DIV_END = QW + 1;
	localparam int ST_ADDR    = QW + 2;
	localparam int ST_ROM     = QW + 3;
	localparam int ST_FAC     = QW + 4;
	localparam int NS         = QW + 5;

	localparam logic [16:0] BIN_MAX = 17'(FFT_LENGTH / 2);

	// ---------------- configuration registers ----------------
	mode_t            mode_q;
	logic [BIN_W-1:0] hp_bin_q, hp_hw_q, lp_bin_q, lp_hw_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= RST_PASS_MODE;
			hp_bin_q <= RST_HP_BIN;
			hp_hw_q  <= RST_HP_HALFWIDTH;
			lp_bin_q <= RST_LP_BIN;
			lp_hw_q  <= RST_LP_HALFWIDTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PASS_MODE:    mode_q   <= cfg_data[1:0];
				CFG_HP_BIN:       hp_bin_q <= cfg_data;
				CFG_HP_HALFWIDTH: hp_hw_q  <= cfg_data;
				CFG_LP_BIN:       lp_bin_q <= cfg_data;
				CFG_LP_HALFWIDTH: lp_hw_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic  vld_s [1:NS];
	logic  en    [1:NS];
	item_t itm_s [1:NS];

	assign en[NS] = !vld_s[NS] || !out_stall;
	for (genvar j = 1; j < NS; j++) begin : g_en
		assign en[j] = !vld_s[j] || en[j+1];
	end

	assign in_stall  = !en[1];
	assign out_valid = vld_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= NS; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else begin
			if (en[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int j = 2; j <= NS; j++) begin
				if (en[j]) begin
					vld_s[j] <= vld_s[j-1];
				end
			end
		end
	end

	// ---------------- decode: region of each factor ----------------
	logic [BIN_W-1:0]   hw_eff, hp_edge;
	logic [DW-1:0]      hp_hi, lp_hi, d_h, d_l;
	logic               hp_on;
	logic signed [11:0] lp_edge, bin_sx;
	item_t              dec;
	logic [KW-1:0]      k_h, k_l;

	assign hw_eff  = (hp_hw_q == '0) ? HP_HALFWIDTH_ZERO_SUB : hp_hw_q;
	assign hp_hi   = {1'b0, hp_bin_q} + {1'b0, hw_eff};
	assign hp_edge = hp_bin_q - hw_eff;
	assign hp_on   = (mode_q != MODE_LOW) && ({1'b0, hp_bin_q} > ({1'b0, hw_eff} + 11'd1));
	assign lp_hi   = {1'b0, lp_bin_q} + {1'b0, lp_hw_q};
	assign lp_edge = $signed({2'b00, lp_bin_q}) - $signed({2'b00, lp_hw_q});
	assign bin_sx  = $signed({2'b00, bin_index});
	assign d_h     = {hw_eff, 1'b0};
	assign d_l     = {lp_hw_q, 1'b0};

	always_comb begin
		dec.bin  = bin_index;
		dec.over = ({7'd0, bin_index} > BIN_MAX);
		k_h      = '0;
		k_l      = '0;

		if (!hp_on) begin
			dec.hp_sel = SEL_ONE;
		end else if (bin_index <= hp_edge) begin
			dec.hp_sel = SEL_ZERO;
		end else if ({1'b0, bin_index} >= hp_hi) begin
			dec.hp_sel = SEL_ONE;
		end else begin
			dec.hp_sel = SEL_TAPER;
			k_h        = {1'b0, bin_index - hp_edge};
		end

		if (mode_q == MODE_HIGH) begin
			dec.lp_sel = SEL_ONE;
		end else if (lp_hw_q == '0) begin
			dec.lp_sel = (bin_index >= lp_bin_q) ? SEL_ZERO : SEL_ONE;
		end else if (bin_sx <= lp_edge) begin
			dec.lp_sel = SEL_ONE;
		end else if ({1'b0, bin_index} >= lp_hi) begin
			dec.lp_sel = SEL_ZERO;
		end else begin
			dec.lp_sel = SEL_TAPER;
			k_l        = KW'(bin_sx - lp_edge);
		end
	end

	// ---------------- phase quotient q = (k*N + w) / (2w), one bit per stage ----
	logic [NW-1:0] hp_rem_sd [ST_DEC:ST_DIV_END];
	logic [NW-1:0] lp_rem_sd [ST_DEC:ST_DIV_END];
	logic [QW-1:0] hp_quo_sd [ST_DEC:ST_DIV_END];
	logic [QW-1:0] lp_quo_sd [ST_DEC:ST_DIV_END];

	always_ff @(posedge clk) begin
		if (en[ST_DEC]) begin
			itm_s[ST_DEC]     <= dec;
			hp_rem_sd[ST_DEC] <= (NW'(k_h) << TAPER_TABLE_BITS) + NW'(hw_eff);
			lp_rem_sd[ST_DEC] <= (NW'(k_l) << TAPER_TABLE_BITS) + NW'(lp_hw_q);
			hp_quo_sd[ST_DEC] <= '0;
			lp_quo_sd[ST_DEC] <= '0;
		end
		for (int j = 2; j <= NS; j++) begin
			if (en[j]) begin
				itm_s[j] <= itm_s[j-1];
			end
		end
	end

	// divisors read registers; user, not block, keeps them still with items in flight
	for (genvar j = ST_DEC + 1; j <= ST_DIV_END; j++) begin : g_div
		localparam int BIT = ST_DIV_END - j;
		logic [NW-1:0] h_trial, l_trial;

		assign h_trial = NW'(d_h) << BIT;
		assign l_trial = NW'(d_l) << BIT;

		always_ff @(posedge clk) begin
			if (en[j]) begin
				if (hp_rem_sd[j-1] >= h_trial) begin
					hp_rem_sd[j] <= hp_rem_sd[j-1] - h_trial;
					hp_quo_sd[j] <= {hp_quo_sd[j-1][QW-2:0], 1'b1};
				end else begin
					hp_rem_sd[j] <= hp_rem_sd[j-1];
					hp_quo_sd[j] <= {hp_quo_sd[j-1][QW-2:0], 1'b0};
				end
				if (lp_rem_sd[j-1] >= l_trial) begin
					lp_rem_sd[j] <= lp_rem_sd[j-1] - l_trial;
					lp_quo_sd[j] <= {lp_quo_sd[j-1][QW-2:0], 1'b1};
				end else begin
					lp_rem_sd[j] <= lp_rem_sd[j-1];
					lp_quo_sd[j] <= {lp_quo_sd[j-1][QW-2:0], 1'b0};
				end
			end
		end
	end

	// ---------------- fold the phase onto the half table ----------------
	logic [QW-1:0] hq, lq;
	logic          hp_mir_sa, lp_mir_sa, hp_mir_sr, lp_mir_sr;
	logic [AW-1:0] hp_addr_sa, lp_addr_sa;

	assign hq = hp_quo_sd[ST_DIV_END];
	assign lq = lp_quo_sd[ST_DIV_END];

	always_ff @(posedge clk) begin
		if (en[ST_ADDR]) begin
			hp_mir_sa  <= (hq > QW'(HALF));
			lp_mir_sa  <= (lq > QW'(HALF));
			hp_addr_sa <= (hq > QW'(HALF)) ? AW'(QW'(N) - hq) : AW'(hq);
			lp_addr_sa <= (lq > QW'(HALF)) ? AW'(QW'(N) - lq) : AW'(lq);
		end
	end

	// ---------------- sin^2 table, two registered read ports ----------------
	logic [15:0] taper_rom [0:HALF];
	logic [15:0] hp_tab_sr, lp_tab_sr;

	for (genvar g = 0; g <= HALF; g++) begin : g_rom
		assign taper_rom[g] = sin_sq_q15(64'(g), TAPER_TABLE_BITS);
	end

	always_ff @(posedge clk) begin
		if (en[ST_ROM]) begin
			hp_tab_sr <= taper_rom[hp_addr_sa];
			lp_tab_sr <= taper_rom[lp_addr_sa];
			hp_mir_sr <= hp_mir_sa;
			lp_mir_sr <= lp_mir_sa;
		end
	end

	// ---------------- factors ----------------
	logic [GAIN_W-1:0] hp_rise, lp_rise, hp_fac, lp_fac;
	logic [GAIN_W-1:0] hp_fac_sf, lp_fac_sf;

	assign hp_rise = hp_mir_sr ? (ONE_Q15 - hp_tab_sr) : hp_tab_sr;
	assign lp_rise = lp_mir_sr ? (ONE_Q15 - lp_tab_sr) : lp_tab_sr;

	always_comb begin
		unique case (itm_s[ST_ROM].hp_sel)
			SEL_ZERO:  hp_fac = '0;
			SEL_TAPER: hp_fac = hp_rise;
			default:   hp_fac = ONE_Q15;
		endcase
		unique case (itm_s[ST_ROM].lp_sel)
			SEL_ZERO:  lp_fac = '0;
			SEL_TAPER: lp_fac = ONE_Q15 - lp_rise;
			default:   lp_fac = ONE_Q15;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[ST_FAC]) begin
			hp_fac_sf <= hp_fac;
			lp_fac_sf <= lp_fac;
		end
	end

	// ---------------- product, rounded Q15 ----------------
	logic [2*GAIN_W-1:0] prod;
	logic [GAIN_W-1:0]   gain_so;

	assign prod = (32'(hp_fac_sf) * 32'(lp_fac_sf)) + 32'd16384;

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			gain_so <= itm_s[ST_FAC].over ? '0 : GAIN_W'(prod >> 15);
		end
	end

	assign bin_out = itm_s[NS].bin;
	assign gain    = gain_so;

	// ---------------- assertions ----------------
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gain <= ONE_Q15))
		else $error("gain above unity");

	a_over_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ({7'd0, bin_out} > BIN_MAX)) |-> (gain == '0))
		else $error("bin beyond spectrum gave nonzero gain");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_stall)
		else $error("input stalled without output backpressure");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[ST_DIV_END] && (itm_s[ST_DIV_END].hp_sel == SEL_TAPER)) |-> (hq <= QW'(N)))
		else $error("high-pass taper phase out of range");

	a_fullness: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && !vld_s[1]) |-> !in_stall)
		else $error("input stalled with an empty first stage");

endmodule

// ===== bench/cosine_taper_band_mask_top_test.sv =====
// Self-checking bench for cosine_taper_band_mask_top: streams bin indexes and checks bin/gain.
// Depends on ctbm_pkg (register codes, mode codes, widths) and the top-level RTL.
// Directed tests cover the register defaults, taper edges and mode codes; the random phases follow.
`timescale 1ns / 100ps

module cosine_taper_band_mask_top_test;
	import ctbm_pkg::*;

	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          DRAIN_CYCLES = 40;
	localparam int          NUM_PHASES   = 32;
	localparam int          PHASE_ITEMS  = 48;
	localparam int          SPECTRUM_TOP = FFT_LENGTH_DEF / 2;
	localparam logic [63:0] PHASE_STEPS  = 64'd1 << TAPER_TABLE_BITS_DEF;
	localparam mode_t       MODE_SPARE   = 2'd3;

	typedef struct {
		logic [BIN_W-1:0]  bin;
		logic [GAIN_W-1:0] gain;
	} bin_gain_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [BIN_W-1:0]    bin_index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [BIN_W-1:0]    bin_out;
	logic [GAIN_W-1:0]   gain;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	cfg_idx_t            cfg_index = CFG_PASS_MODE;
	logic [CFG_W-1:0]    cfg_data  = '0;

	// mirror of the mask registers
	mode_t            mask_mode   = RST_PASS_MODE;
	logic [BIN_W-1:0] hp_edge_bin = RST_HP_BIN;
	logic [BIN_W-1:0] hp_half     = RST_HP_HALFWIDTH;
	logic [BIN_W-1:0] lp_edge_bin = RST_LP_BIN;
	logic [BIN_W-1:0] lp_half     = RST_LP_HALFWIDTH;

	bin_gain_t pending_gains[$];
	bin_gain_t oldest_gain;
	int        mismatch_count = 0;
	int        cycle_count    = 0;
	int        burst_left     = 0;
	bit        gaps_on        = 1'b1;
	int        stall_left     = 0;
	int        stall_style    = 0;

	cosine_taper_band_mask_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.bin_index (bin_index),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bin_out   (bin_out),
		.gain      (gain),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// sin^2(pi/2 * q/N) in Q15 via a 5-term Taylor series in Q30
	function automatic logic [15:0] half_sine_sq(input logic [63:0] q);
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] sq;
		y    = (PI_Q30 * q) / (64'd2 * PHASE_STEPS);
		y2   = (y * y) >> 30;
		term = y;
		acc  = y;
		for (int n = 1; n <= 4; n++) begin
			term = ((term * y2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		sq = (acc * acc) >> 30;
		return 16'((sq + 64'd16384) >> 15);
	endfunction

	// rising raised-cosine edge at offset k into a taper of half width w
	function automatic logic [31:0] cos_edge_rise(input int k, input int w);
		logic [63:0] q;
		q = (64'(k) * PHASE_STEPS + 64'(w)) / (64'd2 * 64'(w));
		if (q > PHASE_STEPS) begin
			q = PHASE_STEPS;
		end
		if (q <= PHASE_STEPS / 2) begin
			return 32'(half_sine_sq(q));
		end
		return 32'(ONE_Q15) - 32'(half_sine_sq(PHASE_STEPS - q));
	endfunction

	function automatic logic [GAIN_W-1:0] band_gain(input logic [BIN_W-1:0] bin);
		int          s;
		int          h;
		int          l;
		int          w;
		int          e;
		logic [31:0] hp;
		logic [31:0] lp;
		logic [63:0] prod;
		s  = int'(bin);
		hp = 32'(ONE_Q15);
		lp = 32'(ONE_Q15);
		if (mask_mode != MODE_LOW) begin
			h = int'(hp_edge_bin);
			w = (hp_half == 0) ? int'(HP_HALFWIDTH_ZERO_SUB) : int'(hp_half);
			// edge too close to bin 0: high-pass is bypassed
			if (h > w + 1) begin
				e = h - w;
				if (s <= e) begin
					hp = 0;
				end else if (s >= h + w) begin
					hp = 32'(ONE_Q15);
				end else begin
					hp = cos_edge_rise(s - e, w);
				end
			end
		end
		if (mask_mode != MODE_HIGH) begin
			l = int'(lp_edge_bin);
			w = int'(lp_half);
			if (w == 0) begin
				lp = (s >= l) ? 32'd0 : 32'(ONE_Q15);
			end else begin
				e = l - w;
				if (s <= e) begin
					lp = 32'(ONE_Q15);
				end else if (s >= l + w) begin
					lp = 0;
				end else begin
					lp = 32'(ONE_Q15) - cos_edge_rise(s - e, w);
				end
			end
		end
		prod = 64'(hp) * 64'(lp) + 64'd16384;
		if (s > SPECTRUM_TOP) begin
			return '0;
		end
		return GAIN_W'(prod >> 15);
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PASS_MODE:    mask_mode   = value[1:0];
			CFG_HP_BIN:       hp_edge_bin = value;
			CFG_HP_HALFWIDTH: hp_half     = value;
			CFG_LP_BIN:       lp_edge_bin = value;
			CFG_LP_HALFWIDTH: lp_half     = value;
			default: ;
		endcase
	endtask

	// cfg_valid stays high across the five transfers
	task automatic program_mask(input mode_t m, input logic [BIN_W-1:0] hb,
			input logic [BIN_W-1:0] hw, input logic [BIN_W-1:0] lb,
			input logic [BIN_W-1:0] lw);
		write_reg(CFG_PASS_MODE, CFG_W'(m));
		write_reg(CFG_HP_BIN, hb);
		write_reg(CFG_HP_HALFWIDTH, hw);
		write_reg(CFG_LP_BIN, lb);
		write_reg(CFG_LP_HALFWIDTH, lw);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_bin(input logic [BIN_W-1:0] bin);
		int        gap;
		bin_gain_t want;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 8) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		bin_index <= bin;
		do @(posedge clk); while (in_stall);
		want.bin  = bin;
		want.gain = band_gain(bin);
		pending_gains.push_back(want);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_gains.size() != 0) @(posedge clk);
	endtask

	function automatic logic [BIN_W-1:0] pick_bin();
		int r;
		int c;
		int span;
		int v;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			return BIN_W'($urandom_range(0, 1023));
		end
		if (r < 50) begin
			return BIN_W'($urandom_range(0, SPECTRUM_TOP));
		end
		// aim at one of the two tapers
		if (r < 75) begin
			c    = int'(hp_edge_bin);
			span = ((hp_half == 0) ? 3 : int'(hp_half)) + 3;
		end else begin
			c    = int'(lp_edge_bin);
			span = int'(lp_half) + 3;
		end
		v = c - span + int'($urandom_range(0, 2 * span));
		if (v < 0) begin
			v = 0;
		end else if (v > 1023) begin
			v = 1023;
		end
		return BIN_W'(v);
	endfunction

	function automatic logic [BIN_W-1:0] pick_edge();
		case ($urandom_range(0, 5))
			0:       return BIN_W'($urandom_range(0, 40));
			1, 2:    return BIN_W'($urandom_range(0, SPECTRUM_TOP));
			3:       return BIN_W'($urandom_range(0, 1023));
			4:       return BIN_W'(SPECTRUM_TOP);
			default: return BIN_W'($urandom_range(SPECTRUM_TOP - 64, SPECTRUM_TOP));
		endcase
	endfunction

	function automatic logic [BIN_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0:          return '0;
			1, 2, 3, 4: return BIN_W'($urandom_range(1, 8));
			5, 6, 7:    return BIN_W'($urandom_range(1, 64));
			8:          return BIN_W'($urandom_range(1, 512));
			default:    return BIN_W'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_bin(10'd0);
		send_bin(10'd511);
		send_bin(10'd512);
		send_bin(10'd513);
		send_bin(10'd1023);
		wait_drained();
	endtask

	// zero high-pass width acts as 3; soft low-pass edge
	task automatic test_band_edges();
		program_mask(MODE_BAND, 10'd100, 10'd0, 10'd300, 10'd20);
		send_bin(10'd96);
		send_bin(10'd98);
		send_bin(10'd100);
		send_bin(10'd102);
		send_bin(10'd103);
		send_bin(10'd280);
		send_bin(10'd290);
		send_bin(10'd300);
		send_bin(10'd319);
		send_bin(10'd320);
		wait_drained();
	endtask

	// hard low-pass cut under the low and spare mode codes, which the high mode code bypasses
	task automatic test_mode_codes();
		program_mask(MODE_LOW, 10'd50, 10'd10, 10'd200, 10'd0);
		send_bin(10'd45);
		send_bin(10'd199);
		send_bin(10'd200);
		wait_drained();
		program_mask(MODE_HIGH, 10'd50, 10'd10, 10'd200, 10'd0);
		send_bin(10'd45);
		send_bin(10'd55);
		send_bin(10'd600);
		wait_drained();
		program_mask(MODE_SPARE, 10'd50, 10'd10, 10'd200, 10'd0);
		send_bin(10'd45);
		send_bin(10'd199);
		wait_drained();
	endtask

	task automatic test_random_masks();
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0:       program_mask(MODE_BAND, 10'd0, 10'd0, 10'd0, 10'd0);
				1:       program_mask(MODE_BAND, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
				2:       program_mask(MODE_BAND, 10'd512, 10'd512, 10'd512, 10'd512);
				3:       program_mask(MODE_HIGH, 10'd1023, 10'd1, 10'd0, 10'd1);
				4:       program_mask(MODE_LOW, 10'd5, 10'd1, 10'd1023, 10'd1);
				default: program_mask(mode_t'($urandom_range(0, 3)), pick_edge(),
						pick_width(), pick_edge(), pick_width());
			endcase
			gaps_on = (phase % 4 != 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold off mid-phase until the pipe is empty
				if (phase == 6 && i == PHASE_ITEMS / 2) begin
					wait_drained();
				end
				send_bin(pick_bin());
			end
			wait_drained();
		end
	endtask

	// receiver stall: windows of no stall, light, heavy and long-run stall
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style <= $urandom_range(0, 3);
			stall_left  <= $urandom_range(16, 96);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 1) == 1);
			2:       out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ($urandom_range(0, 19) == 0) ? ~out_stall : out_stall;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_gains.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected transfer: bin %0d gain %0d", bin_out, gain);
				end
			end else begin
				oldest_gain = pending_gains.pop_front();
				if (bin_out !== oldest_gain.bin || gain !== oldest_gain.gain) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: bin exp %0d got %0d, gain exp %0d got %0d",
							oldest_gain.bin, bin_out, oldest_gain.gain, gain);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_band_edges();
		test_mode_codes();
		test_random_masks();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_gains.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/ctbm_pkg.sv
rtl/core/cosine_taper_band_mask_top.sv
bench/cosine_taper_band_mask_top_test.sv
